### hdl/rvdec_pkg.sv
package rvdec_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned MN_W   = 6;
    localparam int unsigned REG_W  = 5;

    // opcodes
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_JALR   = 7'h67;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    // mnemonic codes
    localparam logic [MN_W-1:0] MN_ADD   = 6'd0;
    localparam logic [MN_W-1:0] MN_SUB   = 6'd1;
    localparam logic [MN_W-1:0] MN_SLL   = 6'd2;
    localparam logic [MN_W-1:0] MN_SLT   = 6'd3;
    localparam logic [MN_W-1:0] MN_SLTU  = 6'd4;
    localparam logic [MN_W-1:0] MN_XOR   = 6'd5;
    localparam logic [MN_W-1:0] MN_SRL   = 6'd6;
    localparam logic [MN_W-1:0] MN_SRA   = 6'd7;
    localparam logic [MN_W-1:0] MN_OR    = 6'd8;
    localparam logic [MN_W-1:0] MN_AND   = 6'd9;
    localparam logic [MN_W-1:0] MN_LB    = 6'd10;
    localparam logic [MN_W-1:0] MN_LH    = 6'd11;
    localparam logic [MN_W-1:0] MN_LW    = 6'd12;
    localparam logic [MN_W-1:0] MN_LBU   = 6'd13;
    localparam logic [MN_W-1:0] MN_LHU   = 6'd14;
    localparam logic [MN_W-1:0] MN_ADDI  = 6'd15;
    localparam logic [MN_W-1:0] MN_SLTI  = 6'd16;
    localparam logic [MN_W-1:0] MN_SLTIU = 6'd17;
    localparam logic [MN_W-1:0] MN_XORI  = 6'd18;
    localparam logic [MN_W-1:0] MN_ORI   = 6'd19;
    localparam logic [MN_W-1:0] MN_ANDI  = 6'd20;
    localparam logic [MN_W-1:0] MN_SLLI  = 6'd21;
    localparam logic [MN_W-1:0] MN_SRLI  = 6'd22;
    localparam logic [MN_W-1:0] MN_SRAI  = 6'd23;
    localparam logic [MN_W-1:0] MN_BEQ   = 6'd24;
    localparam logic [MN_W-1:0] MN_BNE   = 6'd25;
    localparam logic [MN_W-1:0] MN_BLT   = 6'd26;
    localparam logic [MN_W-1:0] MN_BGE   = 6'd27;
    localparam logic [MN_W-1:0] MN_BLTU  = 6'd28;
    localparam logic [MN_W-1:0] MN_BGEU  = 6'd29;
    localparam logic [MN_W-1:0] MN_SB    = 6'd30;
    localparam logic [MN_W-1:0] MN_SH    = 6'd31;
    localparam logic [MN_W-1:0] MN_SW    = 6'd32;
    localparam logic [MN_W-1:0] MN_LUI   = 6'd33;
    localparam logic [MN_W-1:0] MN_AUIPC = 6'd34;
    localparam logic [MN_W-1:0] MN_JAL   = 6'd35;
    localparam logic [MN_W-1:0] MN_JALR  = 6'd36;
    localparam logic [MN_W-1:0] MN_UNKNOWN = 6'd37;

    // decoded result carried from the decode logic to the result register
    typedef struct packed {
        logic              recognized;
        logic [MN_W-1:0]   mnemonic;
        logic [REG_W-1:0]  dest_reg;
        logic [REG_W-1:0]  src_reg_a;
        logic [REG_W-1:0]  src_reg_b;
        logic [WORD_W-1:0] immediate;
    } dec_result_t;

endpackage

### hdl/rvdec_decode.sv
module rvdec_decode
(
    input  logic [rvdec_pkg::WORD_W-1:0] word,
    output rvdec_pkg::dec_result_t       result
);

    logic [6:0]                     opcode;
    logic [2:0]                     funct3;
    logic [6:0]                     funct7;
    logic [rvdec_pkg::MN_W-1:0]     mn;
    logic [rvdec_pkg::WORD_W-1:0]   imm;
    logic [rvdec_pkg::WORD_W-1:0]   imm_i;
    logic [rvdec_pkg::WORD_W-1:0]   imm_s;
    logic [rvdec_pkg::WORD_W-1:0]   imm_b;
    logic [rvdec_pkg::WORD_W-1:0]   imm_u;
    logic [rvdec_pkg::WORD_W-1:0]   imm_j;
    logic [rvdec_pkg::WORD_W-1:0]   shamt;

    assign opcode = word[6:0];
    assign funct3 = word[14:12];
    assign funct7 = word[31:25];

    assign imm_i = {{20{word[31]}}, word[31:20]};
    assign imm_s = {{20{word[31]}}, word[31:25], word[11:7]};
    assign imm_b = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
    assign imm_u = {word[31:12], 12'h000};
    assign imm_j = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};
    assign shamt = {27'd0, word[24:20]};

    always_comb
    begin
        mn  = rvdec_pkg::MN_UNKNOWN;
        imm = '0;
        case (opcode)
            rvdec_pkg::OP_REG:
            begin
                if (funct7 == rvdec_pkg::F7_BASE)
                begin
                    case (funct3)
                        3'd0:    mn = rvdec_pkg::MN_ADD;
                        3'd1:    mn = rvdec_pkg::MN_SLL;
                        3'd2:    mn = rvdec_pkg::MN_SLT;
                        3'd3:    mn = rvdec_pkg::MN_SLTU;
                        3'd4:    mn = rvdec_pkg::MN_XOR;
                        3'd5:    mn = rvdec_pkg::MN_SRL;
                        3'd6:    mn = rvdec_pkg::MN_OR;
                        default: mn = rvdec_pkg::MN_AND;
                    endcase
                end
                else if (funct7 == rvdec_pkg::F7_ALT)
                begin
                    if (funct3 == 3'd0)
                        mn = rvdec_pkg::MN_SUB;
                    else if (funct3 == 3'd5)
                        mn = rvdec_pkg::MN_SRA;
                end
            end
            rvdec_pkg::OP_LOAD:
            begin
                imm = imm_i;
                case (funct3)
                    3'd0:    mn = rvdec_pkg::MN_LB;
                    3'd1:    mn = rvdec_pkg::MN_LH;
                    3'd2:    mn = rvdec_pkg::MN_LW;
                    3'd4:    mn = rvdec_pkg::MN_LBU;
                    3'd5:    mn = rvdec_pkg::MN_LHU;
                    default: mn = rvdec_pkg::MN_UNKNOWN;
                endcase
            end
            rvdec_pkg::OP_IMM:
            begin
                case (funct3)
                    3'd1:
                    begin
                        if (funct7 == rvdec_pkg::F7_BASE)
                        begin
                            mn  = rvdec_pkg::MN_SLLI;
                            imm = shamt;
                        end
                    end
                    3'd5:
                    begin
                        if (funct7 == rvdec_pkg::F7_BASE)
                        begin
                            mn  = rvdec_pkg::MN_SRLI;
                            imm = shamt;
                        end
                        else if (funct7 == rvdec_pkg::F7_ALT)
                        begin
                            mn  = rvdec_pkg::MN_SRAI;
                            imm = shamt;
                        end
                    end
                    3'd0:
                    begin
                        mn  = rvdec_pkg::MN_ADDI;
                        imm = imm_i;
                    end
                    3'd2:
                    begin
                        mn  = rvdec_pkg::MN_SLTI;
                        imm = imm_i;
                    end
                    3'd3:
                    begin
                        mn  = rvdec_pkg::MN_SLTIU;
                        imm = imm_i;
                    end
                    3'd4:
                    begin
                        mn  = rvdec_pkg::MN_XORI;
                        imm = imm_i;
                    end
                    3'd6:
                    begin
                        mn  = rvdec_pkg::MN_ORI;
                        imm = imm_i;
                    end
                    default:
                    begin
                        mn  = rvdec_pkg::MN_ANDI;
                        imm = imm_i;
                    end
                endcase
            end
            rvdec_pkg::OP_BRANCH:
            begin
                imm = imm_b;
                case (funct3)
                    3'd0:    mn = rvdec_pkg::MN_BEQ;
                    3'd1:    mn = rvdec_pkg::MN_BNE;
                    3'd4:    mn = rvdec_pkg::MN_BLT;
                    3'd5:    mn = rvdec_pkg::MN_BGE;
                    3'd6:    mn = rvdec_pkg::MN_BLTU;
                    3'd7:    mn = rvdec_pkg::MN_BGEU;
                    default: mn = rvdec_pkg::MN_UNKNOWN;
                endcase
            end
            rvdec_pkg::OP_STORE:
            begin
                imm = imm_s;
                case (funct3)
                    3'd0:    mn = rvdec_pkg::MN_SB;
                    3'd1:    mn = rvdec_pkg::MN_SH;
                    3'd2:    mn = rvdec_pkg::MN_SW;
                    default: mn = rvdec_pkg::MN_UNKNOWN;
                endcase
            end
            rvdec_pkg::OP_LUI:
            begin
                mn  = rvdec_pkg::MN_LUI;
                imm = imm_u;
            end
            rvdec_pkg::OP_AUIPC:
            begin
                mn  = rvdec_pkg::MN_AUIPC;
                imm = imm_u;
            end
            rvdec_pkg::OP_JAL:
            begin
                mn  = rvdec_pkg::MN_JAL;
                imm = imm_j;
            end
            rvdec_pkg::OP_JALR:
            begin
                if (funct3 == 3'd0)
                    mn = rvdec_pkg::MN_JALR;
                imm = imm_i;
            end
            default:
            begin
                mn  = rvdec_pkg::MN_UNKNOWN;
                imm = '0;
            end
        endcase
    end

    // unknown words give a zero immediate
    always_comb
    begin
        result.recognized = (mn != rvdec_pkg::MN_UNKNOWN);
        result.mnemonic   = mn;
        result.dest_reg   = word[11:7];
        result.src_reg_a  = word[19:15];
        result.src_reg_b  = word[24:20];
        result.immediate  = (mn == rvdec_pkg::MN_UNKNOWN) ? '0 : imm;
    end

endmodule

### hdl/rv32i_instruction_decoder.sv
// rv32i instruction decoder
// the result strobe follows the start transfer through the input register and the result register
// throughput: one instruction per cycle; busy is tied low, so start may be held every cycle
// reset: rst_n asynchronous active low clears the valid flags; no result strobes until
// a start transfer; the receiver cannot stall, so results are never held back
module rv32i_instruction_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] instr_word,
    output logic        done,
    output logic        recognized,
    output logic [5:0]  mnemonic,
    output logic [4:0]  dest_reg,
    output logic [4:0]  src_reg_a,
    output logic [4:0]  src_reg_b,
    output logic signed [31:0] immediate
);

    // input stage
    logic                          in_valid_reg;
    logic [rvdec_pkg::WORD_W-1:0]  word_reg;

    // result stage
    logic                          out_valid_reg;
    rvdec_pkg::dec_result_t        result_reg;
    rvdec_pkg::dec_result_t        result_next;

    // nothing ever holds the pipeline, every start is a transfer
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= start;
            out_valid_reg <= in_valid_reg;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (start)
            word_reg <= instr_word;
        if (in_valid_reg)
            result_reg <= result_next;
    end

    // single pass decode between the two registers
    rvdec_decode u_decode
    (
        .word   (word_reg),
        .result (result_next)
    );

    assign done       = out_valid_reg;
    assign recognized = result_reg.recognized;
    assign mnemonic   = result_reg.mnemonic;
    assign dest_reg   = result_reg.dest_reg;
    assign src_reg_a  = result_reg.src_reg_a;
    assign src_reg_b  = result_reg.src_reg_b;
    assign immediate  = $signed(result_reg.immediate);

    // a start transfer strobes done once it has passed the input register and the result register
    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##2 done)
        else $error("start transfer not followed by done");

    // done only follows a start transfer
    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 2))
        else $error("done without a start transfer");

    // recognized and the unknown code agree
    a_recog_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (recognized == (mnemonic != rvdec_pkg::MN_UNKNOWN)))
        else $error("recognized flag disagrees with mnemonic");

    // unknown words carry a zero immediate
    a_unknown_imm: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !recognized) |-> (immediate == 32'sd0))
        else $error("unknown word with nonzero immediate");

    // register fields are the raw word fields
    a_reg_fields: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##2 (dest_reg == $past(instr_word[11:7], 2)
                       && src_reg_a == $past(instr_word[19:15], 2)
                       && src_reg_b == $past(instr_word[24:20], 2)))
        else $error("register field mismatch");

endmodule

### sim/decode_check_pkg.sv
`timescale 1ns / 1ps

package decode_check_pkg;

    import rvdec_pkg::*;

    // funct3 codes of the base integer set
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_BYTE   = 3'd0;
    localparam logic [2:0] F3_HALF   = 3'd1;
    localparam logic [2:0] F3_WORD   = 3'd2;
    localparam logic [2:0] F3_BYTE_U = 3'd4;
    localparam logic [2:0] F3_HALF_U = 3'd5;
    localparam logic [2:0] F3_LD_GAP = 3'd3;
    localparam logic [2:0] F3_ST_GAP = 3'd3;

    localparam logic [2:0] F3_BEQ    = 3'd0;
    localparam logic [2:0] F3_BNE    = 3'd1;
    localparam logic [2:0] F3_BR_GAP = 3'd2;
    localparam logic [2:0] F3_BLT    = 3'd4;
    localparam logic [2:0] F3_BGE    = 3'd5;
    localparam logic [2:0] F3_BLTU   = 3'd6;
    localparam logic [2:0] F3_BGEU   = 3'd7;

    localparam logic [2:0] F3_JALR = 3'd0;

    class decode_scoreboard;

        dec_result_t expected_decodes[$];
        int unsigned fail_count;

        function new();
            fail_count = 0;
        endfunction

        function dec_result_t expected_decode(logic [31:0] w);
            dec_result_t r;
            logic [6:0] op;
            logic [2:0] f3;
            logic [6:0] f7;
            logic [31:0] imm_i;
            logic [31:0] shamt;
            op    = w[6:0];
            f3    = w[14:12];
            f7    = w[31:25];
            imm_i = {{20{w[31]}}, w[31:20]};
            shamt = {27'd0, w[24:20]};
            r.mnemonic  = MN_UNKNOWN;
            r.immediate = '0;
            case (op)
                OP_REG:
                begin
                    if (f7 == F7_BASE)
                    begin
                        case (f3)
                            F3_ADD:  r.mnemonic = MN_ADD;
                            F3_SLL:  r.mnemonic = MN_SLL;
                            F3_SLT:  r.mnemonic = MN_SLT;
                            F3_SLTU: r.mnemonic = MN_SLTU;
                            F3_XOR:  r.mnemonic = MN_XOR;
                            F3_SR:   r.mnemonic = MN_SRL;
                            F3_OR:   r.mnemonic = MN_OR;
                            default: r.mnemonic = MN_AND;
                        endcase
                    end
                    else if (f7 == F7_ALT)
                    begin
                        if (f3 == F3_ADD)
                            r.mnemonic = MN_SUB;
                        else if (f3 == F3_SR)
                            r.mnemonic = MN_SRA;
                    end
                end
                OP_LOAD:
                begin
                    case (f3)
                        F3_BYTE:   r.mnemonic = MN_LB;
                        F3_HALF:   r.mnemonic = MN_LH;
                        F3_WORD:   r.mnemonic = MN_LW;
                        F3_BYTE_U: r.mnemonic = MN_LBU;
                        F3_HALF_U: r.mnemonic = MN_LHU;
                        default:   r.mnemonic = MN_UNKNOWN;
                    endcase
                    r.immediate = imm_i;
                end
                OP_IMM:
                begin
                    r.immediate = imm_i;
                    case (f3)
                        F3_ADD:  r.mnemonic = MN_ADDI;
                        F3_SLT:  r.mnemonic = MN_SLTI;
                        F3_SLTU: r.mnemonic = MN_SLTIU;
                        F3_XOR:  r.mnemonic = MN_XORI;
                        F3_OR:   r.mnemonic = MN_ORI;
                        F3_AND:  r.mnemonic = MN_ANDI;
                        F3_SLL:
                        begin
                            r.immediate = shamt;
                            if (f7 == F7_BASE)
                                r.mnemonic = MN_SLLI;
                        end
                        default:
                        begin
                            r.immediate = shamt;
                            if (f7 == F7_BASE)
                                r.mnemonic = MN_SRLI;
                            else if (f7 == F7_ALT)
                                r.mnemonic = MN_SRAI;
                        end
                    endcase
                end
                OP_BRANCH:
                begin
                    case (f3)
                        F3_BEQ:  r.mnemonic = MN_BEQ;
                        F3_BNE:  r.mnemonic = MN_BNE;
                        F3_BLT:  r.mnemonic = MN_BLT;
                        F3_BGE:  r.mnemonic = MN_BGE;
                        F3_BLTU: r.mnemonic = MN_BLTU;
                        F3_BGEU: r.mnemonic = MN_BGEU;
                        default: r.mnemonic = MN_UNKNOWN;
                    endcase
                    r.immediate = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
                end
                OP_STORE:
                begin
                    case (f3)
                        F3_BYTE: r.mnemonic = MN_SB;
                        F3_HALF: r.mnemonic = MN_SH;
                        F3_WORD: r.mnemonic = MN_SW;
                        default: r.mnemonic = MN_UNKNOWN;
                    endcase
                    r.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
                end
                OP_LUI:
                begin
                    r.mnemonic  = MN_LUI;
                    r.immediate = {w[31:12], 12'd0};
                end
                OP_AUIPC:
                begin
                    r.mnemonic  = MN_AUIPC;
                    r.immediate = {w[31:12], 12'd0};
                end
                OP_JAL:
                begin
                    r.mnemonic  = MN_JAL;
                    r.immediate = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
                end
                OP_JALR:
                begin
                    if (f3 == F3_JALR)
                        r.mnemonic = MN_JALR;
                    r.immediate = imm_i;
                end
                default: r.mnemonic = MN_UNKNOWN;
            endcase
            if (r.mnemonic == MN_UNKNOWN)
                r.immediate = '0;
            r.recognized = (r.mnemonic != MN_UNKNOWN);
            r.dest_reg   = w[11:7];
            r.src_reg_a  = w[19:15];
            r.src_reg_b  = w[24:20];
            return r;
        endfunction

        function void note_instr(logic [31:0] w);
            expected_decodes.push_back(expected_decode(w));
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s expected 0x%08h actual 0x%08h", $time, name, want, got);
                fail_count++;
            end
        endfunction

        function void check_result(dec_result_t got);
            dec_result_t want;
            if (expected_decodes.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual mnemonic %0d",
                         $time, got.mnemonic);
                fail_count++;
                return;
            end
            want = expected_decodes.pop_front();
            compare_field("recognized", 32'(want.recognized), 32'(got.recognized));
            compare_field("mnemonic",   32'(want.mnemonic),   32'(got.mnemonic));
            compare_field("dest_reg",   32'(want.dest_reg),   32'(got.dest_reg));
            compare_field("src_reg_a",  32'(want.src_reg_a),  32'(got.src_reg_a));
            compare_field("src_reg_b",  32'(want.src_reg_b),  32'(got.src_reg_b));
            compare_field("immediate",  want.immediate,       got.immediate);
        endfunction

        function int unsigned outstanding();
            return expected_decodes.size();
        endfunction

    endclass

endpackage

### sim/tb_rv32i_instruction_decoder.sv
`timescale 1ns / 1ps

module tb_rv32i_instruction_decoder;

    import rvdec_pkg::*;
    import decode_check_pkg::*;

    // number of random instructions after the directed list
    localparam int unsigned RANDOM_INSTRS = 1550;
    // far above the slowest legal run (every instruction after a long gap)
    localparam int unsigned CYCLE_LIMIT   = 400000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] instr_word;
    logic        done;
    logic        recognized;
    logic [5:0]  mnemonic;
    logic [4:0]  dest_reg;
    logic [4:0]  src_reg_a;
    logic [4:0]  src_reg_b;
    logic signed [31:0] immediate;

    decode_scoreboard sb;
    int unsigned      cycle_count = 0;

    rv32i_instruction_decoder dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .instr_word (instr_word),
        .done       (done),
        .recognized (recognized),
        .mnemonic   (mnemonic),
        .dest_reg   (dest_reg),
        .src_reg_a  (src_reg_a),
        .src_reg_b  (src_reg_b),
        .immediate  (immediate)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: a hang or a lost result ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // monitor: values seen here are the ones present before this edge, so the
    // transfer condition and the result strobe are sampled without races
    always @(posedge clk)
    begin
        dec_result_t got;
        if (start && !busy)
            sb.note_instr(instr_word);
        if (done)
        begin
            got.recognized = recognized;
            got.mnemonic   = mnemonic;
            got.dest_reg   = dest_reg;
            got.src_reg_a  = src_reg_a;
            got.src_reg_b  = src_reg_b;
            got.immediate  = immediate;
            sb.check_result(got);
        end
    end

    // hold one instruction on the inputs until the transfer edge
    task automatic send_instr(input logic [31:0] w);
        start      <= 1'b1;
        instr_word <= w;
        do
            @(posedge clk);
        while (busy);
    endtask

    // drop start for an idle stretch set by n; the word lines carry noise meanwhile
    task automatic idle_for(input int unsigned n);
        if (n != 0)
        begin
            start      <= 1'b0;
            instr_word <= $urandom;
            repeat (n) @(posedge clk);
        end
    endtask

    // stop sending until every decoded result has come back
    task automatic drain_results();
        idle_for(1);
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int unsigned random_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // mostly legal encodings with random fields, the rest malformed or noise
    function automatic logic [31:0] random_instr();
        logic [31:0] w;
        logic [6:0]  op;
        logic [2:0]  f3;
        logic [6:0]  f7;
        int unsigned pick;
        w    = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            return w;
        case ($urandom_range(0, 8))
            0:       op = OP_REG;
            1:       op = OP_LOAD;
            2:       op = OP_IMM;
            3:       op = OP_BRANCH;
            4:       op = OP_STORE;
            5:       op = OP_LUI;
            6:       op = OP_AUIPC;
            7:       op = OP_JAL;
            default: op = OP_JALR;
        endcase
        f3 = w[14:12];
        f7 = w[31:25];
        // funct7 only selects the operation for register ops and shifts
        if (op == OP_REG || op == OP_IMM)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                f7 = F7_BASE;
            else if (pick < 90)
                f7 = F7_ALT;
        end
        // jalr is only legal with one funct3 value, so favor it
        if (op == OP_JALR && $urandom_range(0, 3) != 0)
            f3 = F3_JALR;
        return {f7, w[24:15], f3, w[11:7], op};
    endfunction

    initial
    begin
        logic [31:0] directed[$];
        bit          no_gaps;

        sb          = new();
        rst_n       = 1'b0;
        start       = 1'b0;
        instr_word  = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register ops: extreme register fields, alternate funct7, bad funct7
        directed.push_back({F7_BASE, 5'd31, 5'd0, F3_ADD, 5'd31, OP_REG});
        directed.push_back({F7_ALT, 5'd0, 5'd31, F3_ADD, 5'd0, OP_REG});
        directed.push_back({F7_ALT, 5'd17, 5'd5, F3_SR, 5'd9, OP_REG});
        directed.push_back({F7_ALT, 5'd3, 5'd4, F3_XOR, 5'd5, OP_REG});
        directed.push_back({7'h01, 5'd1, 5'd2, F3_ADD, 5'd3, OP_REG});
        directed.push_back({F7_BASE, 5'd31, 5'd31, F3_AND, 5'd31, OP_REG});
        // loads: most negative offset, a plain one, and the unused funct3
        directed.push_back({12'h800, 5'd31, F3_WORD, 5'd1, OP_LOAD});
        directed.push_back({12'h7FF, 5'd2, F3_BYTE_U, 5'd3, OP_LOAD});
        directed.push_back({12'hFFF, 5'd2, F3_LD_GAP, 5'd3, OP_LOAD});
        // immediate ops: largest immediate and minus one
        directed.push_back({12'h7FF, 5'd31, F3_ADD, 5'd31, OP_IMM});
        directed.push_back({12'hFFF, 5'd0, F3_SLT, 5'd0, OP_IMM});
        // shifts: full shift amount, zero amount, wrong funct7
        directed.push_back({F7_BASE, 5'd31, 5'd7, F3_SLL, 5'd8, OP_IMM});
        directed.push_back({F7_ALT, 5'd31, 5'd7, F3_SLL, 5'd8, OP_IMM});
        directed.push_back({F7_BASE, 5'd0, 5'd7, F3_SR, 5'd8, OP_IMM});
        directed.push_back({F7_ALT, 5'd31, 5'd7, F3_SR, 5'd8, OP_IMM});
        directed.push_back({7'h01, 5'd4, 5'd7, F3_SR, 5'd8, OP_IMM});
        // branches: all offset bits set, a positive offset with bit 11 clear, unused funct3
        directed.push_back({7'h7F, 5'd31, 5'd31, F3_BEQ, 5'd31, OP_BRANCH});
        directed.push_back({7'h3F, 5'd1, 5'd2, F3_BGEU, 5'd30, OP_BRANCH});
        directed.push_back({7'h7F, 5'd1, 5'd2, F3_BR_GAP, 5'd31, OP_BRANCH});
        // stores: negative and zero offsets, unused funct3
        directed.push_back({7'h7F, 5'd31, 5'd31, F3_WORD, 5'd31, OP_STORE});
        directed.push_back({7'h00, 5'd0, 5'd0, F3_BYTE, 5'd0, OP_STORE});
        directed.push_back({7'h7F, 5'd5, 5'd6, F3_ST_GAP, 5'd7, OP_STORE});
        // upper immediates and jumps
        directed.push_back({20'hFFFFF, 5'd31, OP_LUI});
        directed.push_back({20'h00001, 5'd0, OP_AUIPC});
        directed.push_back({20'hFFFFF, 5'd31, OP_JAL});
        directed.push_back({20'h7FFFF, 5'd0, OP_JAL});
        directed.push_back({12'h800, 5'd31, F3_JALR, 5'd1, OP_JALR});
        directed.push_back({12'h123, 5'd4, F3_BNE, 5'd1, OP_JALR});
        // all-zero word and all-ones word are both unknown
        directed.push_back(32'h0000_0000);
        directed.push_back(32'hFFFF_FFFF);

        foreach (directed[i])
            send_instr(directed[i]);

        // let the pipe empty before the random part starts
        drain_results();

        no_gaps = 1'b0;
        for (int unsigned i = 0; i < RANDOM_INSTRS; i++)
        begin
            // every hundred transfers pick whether this stretch runs at full rate
            if (i % 100 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            if (i == RANDOM_INSTRS / 2)
                drain_results();
            else if (!no_gaps)
                idle_for(random_gap());
            send_instr(random_instr());
        end

        drain_results();
        // after the drain, the wait below catches any stray strobe
        repeat (6) @(posedge clk);

        if (sb.fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
